// ===== design/abad_pkg.sv =====
// ----------------------------------------------------------------------------
// abad_pkg: shared types and constants for the ASCII box density core
// Field widths, register codes, grey weights and the density ramp.
// ----------------------------------------------------------------------------
package abad_pkg;

	localparam int GREY_W     = 8;
	localparam int CHAR_W     = 7;
	localparam int INT_W      = 28;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOUR_INPUT = 2'd2;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int RADIUS_DEF     = 2;

	localparam int DIM_RESET = 1024;

	// Q16 grey weights
	localparam logic [15:0] W_BLUE  = 16'd7471;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_RED   = 16'd19595;

	localparam int RAMP_STEPS  = 14;
	localparam int RAMP_STEP   = 17;
	localparam int GREY_MAX    = 255;

	typedef logic [3:0] ramp_idx_t;

	typedef struct packed {
		logic first_col;
		logic first_row;
		logic last_col;
		logic res_en;
	} pos_flags_t;

	function automatic logic [CHAR_W-1:0] ramp_char(input ramp_idx_t idx);
		logic [CHAR_W-1:0] ch;
		unique case (idx)
			4'd0:    ch = 7'h20; // ' '
			4'd1:    ch = 7'h27; // '\''
			4'd2:    ch = 7'h2E; // '.'
			4'd3:    ch = 7'h2D; // '-'
			4'd4:    ch = 7'h3A; // ':'
			4'd5:    ch = 7'h2F; // '/'
			4'd6:    ch = 7'h2B; // '+'
			4'd7:    ch = 7'h6F; // 'o'
			4'd8:    ch = 7'h73; // 's'
			4'd9:    ch = 7'h79; // 'y'
			4'd10:   ch = 7'h68; // 'h'
			4'd11:   ch = 7'h64; // 'd'
			4'd12:   ch = 7'h6D; // 'm'
			4'd13:   ch = 7'h4E; // 'N'
			default: ch = 7'h4D; // 'M'
		endcase
		return ch;
	endfunction

endpackage

// ===== design/abad_intf.sv =====
// ----------------------------------------------------------------------------
// abad_intf: valid/ready channel interfaces of the ASCII box density core
// Pixel input, character output and configuration write channels.
// ----------------------------------------------------------------------------
interface abad_pix_if;
	logic                         valid;
	logic                         ready;
	logic [abad_pkg::GREY_W-1:0]  blue_or_grey;
	logic [abad_pkg::GREY_W-1:0]  green;
	logic [abad_pkg::GREY_W-1:0]  red;

	modport source (output valid, output blue_or_grey, output green, output red, input ready);
	modport sink   (input valid, input blue_or_grey, input green, input red, output ready);
endinterface

interface abad_char_if;
	logic                         valid;
	logic                         ready;
	logic [abad_pkg::CHAR_W-1:0]  char_code;
	logic                         row_end;

	modport source (output valid, output char_code, output row_end, input ready);
	modport sink   (input valid, input char_code, input row_end, output ready);
endinterface

interface abad_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [abad_pkg::CFG_IDX_W-1:0]  index;
	logic [abad_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/ascii_art_box_density_core.sv =====
// ----------------------------------------------------------------------------
// ascii_art_box_density_core: streaming box filter to ASCII density characters
// Raster pixels in, one density character per full box window out.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  - valid/ready input, one pixel item per accept, raster order.
//   text   - valid/ready output, one character item per window whose box ends
//            at a pixel at least 2R+1 from the top and left edges; row_end
//            marks the last column of a text row.
//   cfg    - valid/ready register writes, always ready. Writing width or
//            height restarts the frame. Write only while the block is idle.
// Throughput: one pixel per cycle while text is not stalled, set by the two
//   line store reads and one line store write made for every pixel.
// Pipeline: an accepted pixel is registered in stage 1, and its result then in
//   the output register; stage 1 holds while the output register is stalled.
// Reset: counters, row sum and pipeline valids clear; the line store is not
//   cleared; every entry a frame uses is written earlier in that frame.
// Stall: while text is stalled the output register holds; stage 1 holds one
//   more pixel, and pixel ready drops only when both are full.
// ----------------------------------------------------------------------------
module ascii_art_box_density_core #(
	parameter int MAX_WIDTH  = abad_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = abad_pkg::MAX_HEIGHT_DEF,
	parameter int RADIUS     = abad_pkg::RADIUS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	abad_pix_if.sink    pixel,
	abad_char_if.source text,
	abad_cfg_if.sink    cfg
);

	localparam int LR    = 2 * RADIUS + 2;
	localparam int BS    = 2 * RADIUS + 1;
	localparam int AREA  = BS * BS;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WEW   = $clog2(MAX_WIDTH + 1);
	localparam int HEW   = $clog2(MAX_HEIGHT + 1);
	localparam int SW    = $clog2(LR);
	localparam int AW    = $clog2(LR * MAX_WIDTH);
	localparam int RSW   = $clog2(MAX_WIDTH * abad_pkg::GREY_MAX + 1);
	localparam int INT_W = abad_pkg::INT_W;
	localparam int GW    = abad_pkg::GREY_W;

	// configuration
	logic [WEW-1:0] w_eff_q;
	logic [HEW-1:0] h_eff_q;
	logic           colour_q;

	// position state
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [SW-1:0]  slot_q;
	logic [RSW-1:0] rs_q;

	// line store
	logic [INT_W-1:0] integral_mem_q [LR * MAX_WIDTH];

	// stage 1
	logic                   s1_valid;
	logic [GW-1:0]          grey_s1;
	abad_pkg::pos_flags_t   flags_s1;
	logic [AW-1:0]          wr_addr_s1;
	logic                   fwd_s1;
	logic [INT_W-1:0]       fwd_val_s1;
	logic [INT_W-1:0]       above_rd_s1;
	logic [INT_W-1:0]       top_rd_s1;

	logic [INT_W-1:0] cur_line_q [BS];
	logic [INT_W-1:0] top_line_q [BS];

	// output register
	logic                        out_valid_q;
	logic [abad_pkg::CHAR_W-1:0] char_q;
	logic                        row_end_q;

	logic cfg_acc, dim_wr, in_acc, s1_adv;
	logic [GW-1:0]          grey_in;
	logic [23:0]            pb, pg, pr;
	logic [9:0]             grey_sum;
	abad_pkg::pos_flags_t   flags_in;
	logic [SW-1:0]          above_slot, top_slot;
	logic [AW-1:0]          wr_addr_in, above_addr, top_addr;
	logic                   last_col, last_row;
	logic [RSW-1:0]         rs_new;
	logic [INT_W-1:0]       above_val, cur, box;
	abad_pkg::ramp_idx_t    idx;

	assign cfg.ready   = 1'b1;
	assign cfg_acc     = cfg.valid && cfg.ready;
	assign dim_wr      = cfg_acc && (cfg.index == abad_pkg::REG_IMAGE_WIDTH ||
	                                 cfg.index == abad_pkg::REG_IMAGE_HEIGHT);

	assign s1_adv      = s1_valid && (!out_valid_q || text.ready);
	assign pixel.ready = !s1_valid || s1_adv;
	assign in_acc      = pixel.valid && pixel.ready;

	// grey conversion, each product truncated on its own
	always_comb begin
		pb       = 24'(pixel.blue_or_grey) * 24'(abad_pkg::W_BLUE);
		pg       = 24'(pixel.green) * 24'(abad_pkg::W_GREEN);
		pr       = 24'(pixel.red) * 24'(abad_pkg::W_RED);
		grey_sum = 10'(pb[23:16]) + 10'(pg[23:16]) + 10'(pr[23:16]);
		grey_in  = colour_q ? grey_sum[GW-1:0] : pixel.blue_or_grey;
	end

	always_comb begin
		last_col             = (32'(col_q) + 1) == 32'(w_eff_q);
		last_row             = (32'(row_q) + 1) == 32'(h_eff_q);
		flags_in.first_col   = col_q == '0;
		flags_in.first_row   = row_q == '0;
		flags_in.last_col    = last_col;
		flags_in.res_en      = (32'(col_q) >= BS) && (32'(row_q) >= BS);
		above_slot = (slot_q == '0) ? SW'(LR - 1) : slot_q - SW'(1);
		top_slot   = (slot_q == SW'(LR - 1)) ? '0 : slot_q + SW'(1);
		wr_addr_in = AW'(32'(slot_q) * MAX_WIDTH + 32'(col_q));
		above_addr = AW'(32'(above_slot) * MAX_WIDTH + 32'(col_q));
		top_addr   = AW'(32'(top_slot) * MAX_WIDTH + 32'(col_q));
	end

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q  <= WEW'(abad_pkg::DIM_RESET > MAX_WIDTH ? MAX_WIDTH : abad_pkg::DIM_RESET);
			h_eff_q  <= HEW'(abad_pkg::DIM_RESET > MAX_HEIGHT ? MAX_HEIGHT : abad_pkg::DIM_RESET);
			colour_q <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
		end else if (cfg_acc) begin
			unique case (cfg.index)
				abad_pkg::REG_IMAGE_WIDTH: begin
					if (cfg.data == '0)
						w_eff_q <= WEW'(1);
					else if (32'(cfg.data) > MAX_WIDTH)
						w_eff_q <= WEW'(MAX_WIDTH);
					else
						w_eff_q <= WEW'(cfg.data);
				end
				abad_pkg::REG_IMAGE_HEIGHT: begin
					if (cfg.data == '0)
						h_eff_q <= HEW'(1);
					else if (32'(cfg.data) > MAX_HEIGHT)
						h_eff_q <= HEW'(MAX_HEIGHT);
					else
						h_eff_q <= HEW'(cfg.data);
				end
				abad_pkg::REG_COLOUR_INPUT: colour_q <= cfg.data[0];
				default: ;
			endcase
			if (dim_wr) begin
				col_q  <= '0;
				row_q  <= '0;
				slot_q <= '0;
			end
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + RW'(1);
					slot_q <= top_slot;
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line store: one write, two reads per pixel
	always_ff @(posedge clk) begin
		if (s1_adv)
			integral_mem_q[wr_addr_s1] <= cur;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			above_rd_s1 <= integral_mem_q[above_addr];
			top_rd_s1   <= integral_mem_q[top_addr];
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			grey_s1    <= grey_in;
			flags_s1   <= flags_in;
			wr_addr_s1 <= wr_addr_in;
			fwd_s1     <= s1_valid && (wr_addr_s1 == above_addr);
			fwd_val_s1 <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (in_acc)
			s1_valid <= 1'b1;
		else if (s1_adv)
			s1_valid <= 1'b0;
	end

	// integral update and box sum
	always_comb begin
		above_val = flags_s1.first_row ? '0 : (fwd_s1 ? fwd_val_s1 : above_rd_s1);
		rs_new    = flags_s1.first_col ? RSW'(grey_s1) : rs_q + RSW'(grey_s1);
		cur       = INT_W'(rs_new) + above_val;
		box       = cur + top_line_q[BS-1] - cur_line_q[BS-1] - top_rd_s1;
		// avg > t*17 exactly when box >= (17t+1)*area
		idx = '0;
		for (int k = 1; k <= abad_pkg::RAMP_STEPS; k++)
			idx = idx + abad_pkg::ramp_idx_t'(box >= INT_W'((abad_pkg::RAMP_STEP * k + 1) * AREA));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rs_q <= '0;
		else if (dim_wr)
			rs_q <= '0;
		else if (s1_adv)
			rs_q <= rs_new;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cur_line_q[0] <= cur;
			top_line_q[0] <= top_rd_s1;
			for (int i = 1; i < BS; i++) begin
				cur_line_q[i] <= cur_line_q[i-1];
				top_line_q[i] <= top_line_q[i-1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= flags_s1.res_en;
		else if (text.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv && flags_s1.res_en) begin
			char_q    <= abad_pkg::ramp_char(idx);
			row_end_q <= flags_s1.last_col;
		end
	end

	assign text.valid     = out_valid_q;
	assign text.char_code = char_q;
	assign text.row_end   = row_end_q;

`ifndef NO_ASSERTIONS
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		dim_wr |=> (col_q == '0 && row_q == '0 && rs_q == '0 && slot_q == '0))
		else $error("frame did not restart after dimension write");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(w_eff_q))
		else $error("column counter beyond image width");

	a_fwd_width: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && fwd_s1) |-> (w_eff_q == WEW'(1)))
		else $error("line store bypass taken with width above one");
`endif

endmodule

// ===== verif/ascii_art_box_density_core_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_art_box_density_core_tb: self-checking bench for the box density core
// Streams raster pixels through many frame sizes in grey and colour mode,
// including out-of-range sizes. A local integral-image predictor works out
// each density character and its row end, and the text channel is checked
// against it in order. Both channels idle at random, and the pixel side
// pauses at times until the text side has drained.
// ----------------------------------------------------------------------------
module ascii_art_box_density_core_tb;

	localparam int CLK_PERIOD  = 20;
	localparam int RAD         = abad_pkg::RADIUS_DEF;
	localparam int SIDE        = 2 * RAD + 1;
	localparam int AREA        = SIDE * SIDE;
	localparam int SLOTS       = 2 * RAD + 2;
	localparam int WMAX        = abad_pkg::MAX_WIDTH_DEF;
	localparam int HMAX        = abad_pkg::MAX_HEIGHT_DEF;
	localparam int GW          = abad_pkg::GREY_W;
	localparam int CW          = abad_pkg::CHAR_W;
	localparam int IW          = abad_pkg::INT_W;
	localparam int XW          = abad_pkg::CFG_IDX_W;
	localparam int DW          = abad_pkg::CFG_DATA_W;
	localparam int GMAX        = abad_pkg::GREY_MAX;
	localparam int LEVELS      = 15;
	localparam int THRESH_STEP = 17;
	localparam int unsigned GW_BLUE  = 7471;
	localparam int unsigned GW_GREEN = 38470;
	localparam int unsigned GW_RED   = 19595;
	localparam logic [XW-1:0] REG_SPARE = 2'd3;
	localparam byte DENSITY_RAMP [LEVELS] = '{" ", "'", ".", "-", ":", "/", "+", "o",
		"s", "y", "h", "d", "m", "N", "M"};

	typedef enum {MODE_FLAT, MODE_DRIFT, MODE_NOISE, MODE_RAIL} pix_mode_t;

	typedef struct {
		logic [CW-1:0] code;
		logic          row_end;
	} text_item_t;

	class density_scoreboard;
		bit [IW-1:0] isum [SLOTS][WMAX];
		bit [IW-1:0] row_sum;
		int unsigned col;
		int unsigned row;
		bit [DW-1:0] width_reg;
		bit [DW-1:0] height_reg;
		bit          colour;
		text_item_t  due [$];
		int          errors;

		function new();
			width_reg  = DW'(abad_pkg::DIM_RESET);
			height_reg = DW'(abad_pkg::DIM_RESET);
			colour     = 1'b0;
			row_sum    = '0;
			col        = 0;
			row        = 0;
			errors     = 0;
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 40)
				$display("%0t: %s", $time, msg);
		endtask

		function int unsigned clamp_dim(bit [DW-1:0] v, int unsigned lim);
			if (v == 0)
				return 1;
			if (32'(v) > lim)
				return lim;
			return 32'(v);
		endfunction

		function void write_reg(logic [XW-1:0] idx, logic [DW-1:0] data);
			case (idx)
				abad_pkg::REG_IMAGE_WIDTH, abad_pkg::REG_IMAGE_HEIGHT: begin
					if (idx == abad_pkg::REG_IMAGE_WIDTH)
						width_reg = data;
					else
						height_reg = data;
					col     = 0;
					row     = 0;
					row_sum = '0;
				end
				abad_pkg::REG_COLOUR_INPUT: colour = data[0];
				default: ;
			endcase
		endfunction

		function void note_pixel(logic [GW-1:0] b, logic [GW-1:0] g, logic [GW-1:0] r);
			int unsigned w, h, c, y, grey, avg, idx;
			bit [IW-1:0] above, cur, box;
			text_item_t  t;
			w = clamp_dim(width_reg, WMAX);
			h = clamp_dim(height_reg, HMAX);
			c = (col >= w) ? 0 : col;
			y = (row >= h) ? 0 : row;
			if (colour)
				grey = ((GW_BLUE * b) >> 16) + ((GW_GREEN * g) >> 16) + ((GW_RED * r) >> 16);
			else
				grey = 32'(b);
			row_sum = (c == 0) ? IW'(grey) : IW'(row_sum + grey);
			above = (y == 0) ? '0 : isum[(y + SLOTS - 1) % SLOTS][c];
			cur = row_sum + above;
			isum[y % SLOTS][c] = cur;
			if (c >= SIDE && y >= SIDE) begin
				// row y-SIDE shares slot y+1
				box = cur + isum[(y + 1) % SLOTS][c - SIDE] - isum[y % SLOTS][c - SIDE]
					- isum[(y + 1) % SLOTS][c];
				avg = 32'(box) / AREA;
				idx = 0;
				while (idx < LEVELS - 1 && avg > THRESH_STEP * (idx + 1))
					idx++;
				t.code    = DENSITY_RAMP[idx][CW-1:0];
				t.row_end = (c == w - 1);
				due.push_back(t);
			end
			c++;
			if (c >= w) begin
				c = 0;
				y++;
				if (y >= h)
					y = 0;
			end
			col = c;
			row = y;
		endfunction

		task check_char(logic [CW-1:0] code, logic re);
			text_item_t t;
			if (due.size() == 0) begin
				report_mismatch($sformatf("unexpected char %h row_end %b", code, re));
				return;
			end
			t = due.pop_front();
			if (code !== t.code)
				report_mismatch($sformatf("char_code %h, predicted %h", code, t.code));
			if (re !== t.row_end)
				report_mismatch($sformatf("row_end %b, predicted %b", re, t.row_end));
		endtask

		function int pending();
			return due.size();
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	abad_pix_if  pixel ();
	abad_char_if text ();
	abad_cfg_if  cfg ();

	ascii_art_box_density_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.text   (text),
		.cfg    (cfg)
	);

	density_scoreboard sb = new();
	bit src_idle_en;
	bit sink_idle_en;
	int sink_hold;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int gap_len();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	function automatic logic [GW-1:0] near(int level);
		int v;
		v = level + $urandom_range(0, 20) - 10;
		if (v < 0)
			v = 0;
		if (v > GMAX)
			v = GMAX;
		return v[GW-1:0];
	endfunction

	function automatic logic [GW-1:0] rail();
		return ($urandom_range(0, 1) != 0) ? GW'(GMAX) : '0;
	endfunction

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold  <= sink_hold - 1;
			text.ready <= 1'b0;
		end else begin
			text.ready <= 1'b1;
			if (sink_idle_en && $urandom_range(0, 5) == 0)
				sink_hold <= gap_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (text.valid && text.ready)
				sb.check_char(text.char_code, text.row_end);
			if (pixel.valid && pixel.ready)
				sb.note_pixel(pixel.blue_or_grey, pixel.green, pixel.red);
			if (cfg.valid && cfg.ready)
				sb.write_reg(cfg.index, cfg.data);
		end
	end

	task automatic send_pixel(logic [GW-1:0] b, logic [GW-1:0] g, logic [GW-1:0] r);
		int gap;
		gap = (src_idle_en && $urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			pixel.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel.valid        <= 1'b1;
		pixel.blue_or_grey <= b;
		pixel.green        <= g;
		pixel.red          <= r;
		@(posedge clk);
		while (!pixel.ready) @(posedge clk);
	endtask

	task automatic send_frames(int n, pix_mode_t mode, int level);
		int lvl;
		lvl = level;
		for (int i = 0; i < n; i++) begin
			if (mode == MODE_DRIFT && i % 29 == 0)
				lvl = $urandom_range(0, GMAX);
			case (mode)
				MODE_FLAT:  send_pixel(GW'(level), GW'(level), GW'(level));
				MODE_DRIFT: send_pixel(near(lvl), near(lvl), near(lvl));
				MODE_NOISE: send_pixel(GW'($urandom_range(0, GMAX)),
					GW'($urandom_range(0, GMAX)), GW'($urandom_range(0, GMAX)));
				default:    send_pixel(rail(), rail(), rail());
			endcase
		end
	endtask

	// pixel side stops until every predicted character is out
	task automatic wait_idle();
		pixel.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [XW-1:0] idx, logic [DW-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int        budget, w, h, n, k, pick;
		pix_mode_t mode;
		pixel.valid        <= 1'b0;
		pixel.blue_or_grey <= '0;
		pixel.green        <= '0;
		pixel.red          <= '0;
		cfg.valid          <= 1'b0;
		cfg.index          <= '0;
		cfg.data           <= '0;
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest frame holding one box: full scale, zero, colour, rails
		write_reg(abad_pkg::REG_IMAGE_WIDTH, DW'(SIDE + 1));
		write_reg(abad_pkg::REG_IMAGE_HEIGHT, DW'(SIDE + 1));
		write_reg(abad_pkg::REG_COLOUR_INPUT, 11'd0);
		write_reg(REG_SPARE, 11'h7FF);
		send_frames(36, MODE_FLAT, GMAX);
		send_frames(36, MODE_FLAT, 0);
		wait_idle();
		write_reg(abad_pkg::REG_COLOUR_INPUT, 11'h7FF);
		send_frames(36, MODE_FLAT, GMAX);
		send_frames(36, MODE_RAIL, 0);

		// sizes of zero and beyond the maximum
		wait_idle();
		write_reg(abad_pkg::REG_IMAGE_WIDTH, 11'd0);
		send_frames(4, MODE_RAIL, 0);
		wait_idle();
		write_reg(abad_pkg::REG_IMAGE_HEIGHT, 11'd0);
		send_frames(3, MODE_NOISE, 0);
		wait_idle();
		write_reg(abad_pkg::REG_IMAGE_WIDTH, 11'h7FF);
		write_reg(abad_pkg::REG_IMAGE_HEIGHT, 11'h7FF);
		send_frames(8, MODE_RAIL, 0);

		budget = 0;
		while (budget < 640) begin
			wait_idle();
			src_idle_en  = ($urandom_range(0, 3) != 0);
			sink_idle_en = ($urandom_range(0, 3) != 0);
			w = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 48) : $urandom_range(SIDE, 12);
			h = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : $urandom_range(SIDE + 1, 8);
			case ($urandom_range(0, 3))
				0: begin
					write_reg(abad_pkg::REG_IMAGE_WIDTH, DW'(w));
					write_reg(abad_pkg::REG_IMAGE_HEIGHT, DW'(h));
					write_reg(abad_pkg::REG_COLOUR_INPUT, DW'($urandom_range(0, 1)));
				end
				1: write_reg(abad_pkg::REG_IMAGE_WIDTH, DW'(w));
				2: begin
					write_reg(abad_pkg::REG_IMAGE_HEIGHT, DW'(h));
					write_reg(abad_pkg::REG_COLOUR_INPUT, DW'($urandom_range(0, 1)));
				end
				default: write_reg(abad_pkg::REG_COLOUR_INPUT, DW'($urandom_range(0, 1)));
			endcase
			n = $urandom_range(1, 3) * w * h + $urandom_range(0, 2 * w);
			if (n > 100)
				n = 100;
			pick = $urandom_range(0, 99);
			mode = (pick < 70) ? MODE_DRIFT : (pick < 85) ? MODE_NOISE : MODE_RAIL;
			if (n > 10 && $urandom_range(0, 2) == 0) begin
				k = $urandom_range(1, n - 1);
				send_frames(k, mode, 0);
				wait_idle();
				send_frames(n - k, mode, 0);
			end else begin
				send_frames(n, mode, 0);
			end
			budget += n;
		end

		pixel.valid <= 1'b0;
		@(posedge clk);
		for (int i = 0; i < 20000 && sb.pending() != 0; i++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d characters never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("ascii_art_box_density_core_tb: clean");
		else
			$display("ascii_art_box_density_core_tb: errors");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * 5000000);
		$display("ascii_art_box_density_core_tb: errors");
		$finish;
	end

endmodule
